[rtl/core/afp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afp_pkg: shared types and constants of the ASCII frame parser
// Byte codes, reset values and the class record that runs from the
// classifier through the queue to the parser.
// ----------------------------------------------------------------------------
package afp_pkg;

	localparam logic [7:0] BYTE_NL   = 8'h0A;
	localparam logic [7:0] BYTE_ZERO = 8'h30;
	localparam logic [7:0] BYTE_NINE = 8'h39;
	localparam logic [7:0] SEP_RESET = 8'd44;

	localparam int DIGITS_PER_FIELD = 3;
	localparam int QUEUE_DEPTH      = 2;

	localparam int                VALUE_W   = 10;
	localparam logic [VALUE_W-1:0] VALUE_MAX = 10'd1023;
	localparam int                INDEX_W   = 2;

	// Classified byte: several flags may be set at once when the separator
	// equals a digit or a newline.
	typedef struct packed {
		logic       is_digit;
		logic       is_nl;
		logic       is_sep;
		logic [3:0] digit;
	} class_t;

endpackage

[rtl/core/afp_classify.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afp_classify: byte classifier
// Holds the separator register and tags each incoming byte as digit,
// newline and/or separator, with its digit value.
// ----------------------------------------------------------------------------
module afp_classify (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            sep_wr_en,
	input  logic [7:0]      sep_wr_data,
	input  logic [7:0]      rx_byte,
	output afp_pkg::class_t cls
);

	logic [7:0] sep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= afp_pkg::SEP_RESET;
		end else if (sep_wr_en) begin
			sep_q <= sep_wr_data;
		end
	end

	always_comb begin
		cls.is_digit = rx_byte inside {[afp_pkg::BYTE_ZERO:afp_pkg::BYTE_NINE]};
		cls.is_nl    = (rx_byte == afp_pkg::BYTE_NL);
		cls.is_sep   = (rx_byte == sep_q);
		// low nibble of '0'..'9' is the digit value
		cls.digit    = rx_byte[3:0];
	end

endmodule

[rtl/core/afp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afp_queue: small register FIFO
// Decouples the classifier from the parser; stall upstream when full.
// ----------------------------------------------------------------------------
module afp_queue #(
	parameter int WIDTH = 7,
	parameter int DEPTH = afp_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_stall,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_pop,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign wr_stall = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_pop && rd_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/afp_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afp_parser: frame state machine and result register
// Consumes classified bytes, gathers digits, checks terminators and
// registers each completed field.
// ----------------------------------------------------------------------------
module afp_parser #(
	parameter int DIGITS_PER_FIELD = afp_pkg::DIGITS_PER_FIELD
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cls_valid,
	output logic                          cls_pop,
	input  afp_pkg::class_t               cls,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [afp_pkg::INDEX_W-1:0]   field_index,
	output logic [afp_pkg::VALUE_W-1:0]   field_value
);

	localparam int CNT_W = $clog2(DIGITS_PER_FIELD + 1);
	localparam int SUM_W = afp_pkg::VALUE_W + 4;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_F0   = 5'b00010,
		PH_F1   = 5'b00100,
		PH_F2   = 5'b01000,
		PH_F3   = 5'b10000
	} phase_t;

	phase_t                       phase_q, phase_d;
	logic [afp_pkg::VALUE_W-1:0]  acc_q, acc_d;
	logic [CNT_W-1:0]             cnt_q, cnt_d;
	logic [SUM_W-1:0]             acc_sum;
	logic [afp_pkg::VALUE_W-1:0]  acc_sat;
	logic                         term_ok;
	logic                         emit;
	logic [afp_pkg::INDEX_W-1:0]  index_cur;
	logic                         out_valid_q;
	logic [afp_pkg::INDEX_W-1:0]  index_q;
	logic [afp_pkg::VALUE_W-1:0]  value_q;

	// A byte leaves the queue only when the result register can take it.
	assign cls_pop = cls_valid && (!out_valid_q || !out_stall);

	// acc*10 + digit, clamped; once past the limit it stays clamped
	assign acc_sum = (SUM_W'(acc_q) << 3) + (SUM_W'(acc_q) << 1) + SUM_W'(cls.digit);
	assign acc_sat = (acc_sum > SUM_W'(afp_pkg::VALUE_MAX)) ? afp_pkg::VALUE_MAX
	                                                         : acc_sum[afp_pkg::VALUE_W-1:0];

	always_comb begin
		index_cur = '0;
		term_ok   = cls.is_sep;
		case (phase_q)
			PH_F0: index_cur = 2'd0;
			PH_F1: index_cur = 2'd1;
			PH_F2: index_cur = 2'd2;
			PH_F3: begin
				index_cur = 2'd3;
				term_ok   = cls.is_nl;
			end
			default: index_cur = '0;
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		emit    = 1'b0;
		if (cls_pop) begin
			if (phase_q == PH_IDLE) begin
				if (cls.is_nl) begin
					phase_d = PH_F0;
				end
				acc_d = '0;
				cnt_d = '0;
			end else if (cnt_q < CNT_W'(DIGITS_PER_FIELD)) begin
				if (cls.is_digit) begin
					acc_d = acc_sat;
					cnt_d = cnt_q + 1'b1;
				end else begin
					phase_d = PH_IDLE;
					acc_d   = '0;
					cnt_d   = '0;
				end
			end else begin
				acc_d = '0;
				cnt_d = '0;
				if (term_ok) begin
					emit = 1'b1;
					case (phase_q)
						PH_F0:   phase_d = PH_F1;
						PH_F1:   phase_d = PH_F2;
						PH_F2:   phase_d = PH_F3;
						PH_F3:   phase_d = PH_F0;
						default: phase_d = PH_IDLE;
					endcase
				end else begin
					phase_d = PH_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			acc_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			index_q <= index_cur;
			value_q <= acc_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign field_index = index_q;
	assign field_value = value_q;

endmodule

[rtl/core/ascii_four_field_frame_parser.sv]
`timescale 1ns / 1ps
// Path: a byte taken at the input is written to the queue; the parser pops it
//   from the queue head and registers any field beat it completes.
// Throughput: one byte per cycle while the parser is not held; input
//   stalls only once a held field beat has let the two-entry queue fill.
// Reset: arst_n clears state to idle, separator to ',' (44), queue empty.
// ----------------------------------------------------------------------------
// ascii_four_field_frame_parser: four-field decimal frame parser
// Frames are "\n" ddd SEP ddd SEP ddd SEP ddd "\n", where the closing
// newline also opens the next frame. Each completed field is emitted at once
// as (index, value). Any unexpected byte drops the parser back to idle.
// ----------------------------------------------------------------------------
module ascii_four_field_frame_parser #(
	parameter int DIGITS_PER_FIELD = afp_pkg::DIGITS_PER_FIELD,
	parameter int QUEUE_DEPTH      = afp_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// separator register write
	input  logic                          sep_wr_en,
	input  logic [7:0]                    sep_wr_data,
	// received byte beats
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    rx_byte,
	// field result beats
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [afp_pkg::INDEX_W-1:0]   field_index,
	output logic [afp_pkg::VALUE_W-1:0]   field_value
);

	afp_pkg::class_t cls_in;
	afp_pkg::class_t cls_out;
	logic            q_valid;
	logic            q_pop;

	// Front: tag the byte by digit range, newline, separator. The user must
	// change the separator only while idle (unchecked), so early tags are safe.
	afp_classify u_classify (
		.clk         (clk),
		.arst_n      (arst_n),
		.sep_wr_en   (sep_wr_en),
		.sep_wr_data (sep_wr_data),
		.rx_byte     (rx_byte),
		.cls         (cls_in)
	);

	// Short queue so the input keeps flowing while a result waits downstream.
	afp_queue #(
		.WIDTH ($bits(afp_pkg::class_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (in_valid),
		.wr_stall (in_stall),
		.wr_data  (cls_in),
		.rd_valid (q_valid),
		.rd_pop   (q_pop),
		.rd_data  (cls_out)
	);

	// Back: frame state machine, digit accumulator and output register.
	afp_parser #(
		.DIGITS_PER_FIELD (DIGITS_PER_FIELD)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cls_valid   (q_valid),
		.cls_pop     (q_pop),
		.cls         (cls_out),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.field_index (field_index),
		.field_value (field_value)
	);

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the four-field ASCII frame parser
// Byte beats come from a queue that the stimulus process fills. A cycle-free
// parse model turns each accepted byte into the field beats it should cause.
// The monitor checks every field beat, in order, against those expectations.
// The run steps through several separator values (default, 0x00, 0xFF, a
// digit, newline, random) and three idle patterns on both handshakes.
// ----------------------------------------------------------------------------
module tb_top;

	// Time to let bytes that cause no field beat drain out of the block's
	// queue and parser before the separator is touched or the run ends.
	localparam int DRAIN_CYCLES  = 16;
	localparam int BYTES_PER_RUN = 90;

	// Parse position of the model: idle, or expecting field 0..3.
	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_F0   = 5'b00010,
		PH_F1   = 5'b00100,
		PH_F2   = 5'b01000,
		PH_F3   = 5'b10000
	} parse_phase_t;

	typedef struct packed {
		logic [afp_pkg::INDEX_W-1:0] index;
		logic [afp_pkg::VALUE_W-1:0] value;
	} field_beat_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Every block input starts at a known value.
	logic                        sep_wr_en   = 1'b0;
	logic [7:0]                  sep_wr_data = 8'h00;
	logic                        in_valid    = 1'b0;
	logic [7:0]                  rx_byte     = 8'h00;
	logic                        out_stall   = 1'b0;
	logic                        in_stall;
	logic                        out_valid;
	logic [afp_pkg::INDEX_W-1:0] field_index;
	logic [afp_pkg::VALUE_W-1:0] field_value;

	// Bytes waiting to be sent; the head is the beat on the bus once raised.
	logic [7:0]  bytes_to_send[$];
	// Field beats the parse model says are still owed by the block.
	field_beat_t fields_owed[$];

	// Parse model state and its copy of the separator register.
	parse_phase_t         phase       = PH_IDLE;
	int unsigned          field_acc   = 0;
	int                   digits_seen = 0;
	logic [7:0]           sep_char    = afp_pkg::SEP_RESET;

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          errors        = 0;
	field_beat_t got_want;

	logic [7:0] directed_seq [26];

	ascii_four_field_frame_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sep_wr_en  (sep_wr_en),
		.sep_wr_data(sep_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.field_index(field_index),
		.field_value(field_value)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Parse model
	// ------------------------------------------------------------------
	function automatic void open_field(input parse_phase_t p);
		phase       = p;
		field_acc   = 0;
		digits_seen = 0;
	endfunction

	// Advance the model by one accepted byte; a completed field is queued.
	function automatic void parse_byte(input logic [7:0] c);
		logic [7:0]   term;
		field_beat_t  beat;
		parse_phase_t nxt;
		if (phase == PH_IDLE) begin
			// idle: only a newline opens a frame, anything else is dropped
			if (c == afp_pkg::BYTE_NL)
				open_field(PH_F0);
			return;
		end
		// digits are checked first, even when the separator is a digit
		if (digits_seen < afp_pkg::DIGITS_PER_FIELD) begin
			if (c >= afp_pkg::BYTE_ZERO && c <= afp_pkg::BYTE_NINE) begin
				field_acc   = field_acc * 10 + (c - afp_pkg::BYTE_ZERO);
				digits_seen = digits_seen + 1;
			end else begin
				// a newline or separator here aborts and is not reused
				open_field(PH_IDLE);
			end
			return;
		end
		term = (phase == PH_F3) ? afp_pkg::BYTE_NL : sep_char;
		if (c != term) begin
			open_field(PH_IDLE);
			return;
		end
		case (phase)
			PH_F0: begin
				beat.index = 2'd0;
				nxt        = PH_F1;
			end
			PH_F1: begin
				beat.index = 2'd1;
				nxt        = PH_F2;
			end
			PH_F2: begin
				beat.index = 2'd2;
				nxt        = PH_F3;
			end
			default: begin
				// the closing newline of field 3 opens the next frame
				beat.index = 2'd3;
				nxt        = PH_F0;
			end
		endcase
		beat.value = (field_acc > afp_pkg::VALUE_MAX) ? afp_pkg::VALUE_MAX
		                                             : field_acc[afp_pkg::VALUE_W-1:0];
		fields_owed.push_back(beat);
		open_field(nxt);
	endfunction

	// ------------------------------------------------------------------
	// Byte driver: holds a stalled beat, otherwise idles at random
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				parse_byte(rx_byte);
				void'(bytes_to_send.pop_front());
			end
			// one assignment per edge: a held beat is left untouched
			if (!(in_valid && in_stall)) begin
				if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					rx_byte  <= bytes_to_send[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Field monitor: compares each beat with the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (fields_owed.size() == 0) begin
					$display("%0t: unexpected field beat, actual index %0d value %0d",
						$time, field_index, field_value);
					errors++;
				end else begin
					got_want = fields_owed.pop_front();
					if (field_index !== got_want.index) begin
						$display("%0t: field_index expected %0d actual %0d",
							$time, got_want.index, field_index);
						errors++;
					end
					if (field_value !== got_want.value) begin
						$display("%0t: field_value expected %0d actual %0d",
							$time, got_want.value, field_value);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	// Separator writes only with nothing in flight: all bytes taken, all
	// owed fields seen, then a pause for bytes that produce no beat.
	task automatic write_separator(input logic [7:0] v);
		while (bytes_to_send.size() != 0 || fields_owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sep_wr_en   <= 1'b1;
		sep_wr_data <= v;
		@(posedge clk);
		sep_wr_en <= 1'b0;
		sep_char  = v;
	endtask

	// One run of frames: newline, 1..8 fields with random content, sometimes
	// one byte smashed, then a byte that forces idle from any parse state so
	// the next run's newline always opens a frame.
	task automatic queue_frame_run(output int n_bytes);
		logic [7:0] run_bytes[$];
		logic [7:0] b;
		int         nfields;
		int         v;
		int         slot;
		// idle noise ahead of the frame, never a newline
		if ($urandom_range(4) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				b = 8'($urandom_range(255));
				bytes_to_send.push_back((b == afp_pkg::BYTE_NL) ? 8'h0B : b);
			end
		end
		run_bytes.push_back(afp_pkg::BYTE_NL);
		nfields = $urandom_range(1, 8);
		for (int f = 0; f < nfields; f++) begin
			case ($urandom_range(7))
				0: v = 0;
				1: v = 999;
				default: v = $urandom_range(999);
			endcase
			run_bytes.push_back(8'(afp_pkg::BYTE_ZERO + v / 100));
			run_bytes.push_back(8'(afp_pkg::BYTE_ZERO + (v / 10) % 10));
			run_bytes.push_back(8'(afp_pkg::BYTE_ZERO + v % 10));
			run_bytes.push_back((f % 4 == 3) ? afp_pkg::BYTE_NL : sep_char);
		end
		// broken frame: any position, any byte value
		if ($urandom_range(3) == 0) begin
			slot = $urandom_range(run_bytes.size() - 1);
			run_bytes[slot] = 8'($urandom_range(255));
		end
		do
			b = 8'($urandom_range(255));
		while ((b >= afp_pkg::BYTE_ZERO && b <= afp_pkg::BYTE_NINE) ||
			b == afp_pkg::BYTE_NL || b == sep_char);
		run_bytes.push_back(b);
		foreach (run_bytes[i])
			bytes_to_send.push_back(run_bytes[i]);
		n_bytes = run_bytes.size();
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int fed;
		int n;
		int waited;
		logic [7:0] sep_next;

		// Directed bytes with the reset separator ','. Extremes of the byte,
		// idle bytes dropped, a full frame with 999 / 000 / 123 / 456 whose
		// closing newline opens the next frame, a newline where a digit is
		// due, and a newline where field 0's separator is due.
		directed_seq = '{8'h00, 8'hFF, afp_pkg::BYTE_NL,
			"9", "9", "9", ",", "0", "0", "0", ",", "1", "2", "3", ",",
			"4", "5", "6", afp_pkg::BYTE_NL,
			"7", afp_pkg::BYTE_NL,
			afp_pkg::BYTE_NL, "1", "2", "3", afp_pkg::BYTE_NL};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 6; ph++) begin
			// sender 16 / receiver 54, then swapped, then no idling
			case (ph / 2)
				0: begin
					send_idle_pct = 16;
					recv_idle_pct = 54;
				end
				1: begin
					send_idle_pct = 54;
					recv_idle_pct = 16;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase

			if (ph == 0) begin
				foreach (directed_seq[i])
					bytes_to_send.push_back(directed_seq[i]);
			end else begin
				// separators: 0x00, 0xFF, a digit, newline, then random
				case (ph)
					1: sep_next = 8'h00;
					2: sep_next = 8'hFF;
					3: sep_next = "5";
					4: sep_next = afp_pkg::BYTE_NL;
					default: sep_next = 8'($urandom_range(255));
				endcase
				write_separator(sep_next);
			end

			fed = 0;
			while (fed < BYTES_PER_RUN) begin
				queue_frame_run(n);
				fed += n;
			end
		end

		// all bytes taken, then a bounded wait for owed field beats
		while (bytes_to_send.size() != 0)
			@(posedge clk);
		for (waited = 0; waited < 5000 && fields_owed.size() != 0; waited++)
			@(posedge clk);
		if (fields_owed.size() != 0) begin
			$display("%0t: %0d field beats expected but never seen",
				$time, fields_owed.size());
			errors++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
